@@ src/emscal_pkg.sv @@
// shared widths, constants, divider handshake types and month table for the calendar unit
package emscal_pkg;

	// field widths
	localparam int EPOCH_W = 42;
	localparam int ZONE_W = 5;
	localparam int TIME_W = EPOCH_W + 1;
	localparam int ZMS_W = 27;
	localparam int YEAR_W = 12;
	localparam int MONTH_W = 4;
	localparam int MDAY_W = 5;
	localparam int WDAY_W = 3;
	localparam int HOUR_W = 5;
	localparam int MIN_W = 6;
	localparam int SEC_W = 6;
	localparam int MILLI_W = 10;
	localparam int DAYS_W = 16;
	localparam int QUAD_W = 6;
	localparam int DOY_W = 9;

	// serial divider widths
	localparam int DVD_W = EPOCH_W;
	localparam int DSR_W = 27;
	localparam int QUO_W = 17;
	localparam int CNT_W = 5;

	// zone offset register
	localparam logic signed [ZMS_W-1:0] MS_PER_HOUR = 27'sd3600000;
	localparam logic signed [ZMS_W-1:0] ZONE_RST = 27'sd3;
	localparam logic signed [ZMS_W-1:0] ZONE_MS_RST = ZMS_W'(ZONE_RST * MS_PER_HOUR);

	// first instant after the supported span, 47482 days of 86400000 ms
	localparam logic [EPOCH_W-1:0] SPAN_MS = 42'd4102444800000;

	// divisors and quotient bit counts for each division pass
	localparam logic [DSR_W-1:0] DIV_DAY = 27'd86400000;
	localparam logic [DSR_W-1:0] DIV_MILLI = 27'd1000;
	localparam logic [DSR_W-1:0] DIV_SIXTY = 27'd60;
	localparam logic [DSR_W-1:0] DIV_WEEK = 27'd7;
	localparam logic [DSR_W-1:0] DIV_QUAD = 27'd1461;
	localparam logic [CNT_W-1:0] NB_DAY = 5'd16;
	localparam logic [CNT_W-1:0] NB_MILLI = 5'd17;
	localparam logic [CNT_W-1:0] NB_SEC = 5'd11;
	localparam logic [CNT_W-1:0] NB_MIN = 5'd5;
	localparam logic [CNT_W-1:0] NB_WEEK = 5'd14;
	localparam logic [CNT_W-1:0] NB_QUAD = 5'd6;

	// year layout inside a four-year block starting at 1970
	localparam logic [YEAR_W-1:0] FIRST_YEAR = 12'd1970;
	localparam logic [10:0] QY1 = 11'd365;
	localparam logic [10:0] QY2 = 11'd730;
	localparam logic [10:0] QY3 = 11'd1096;
	localparam logic [1:0] LEAP_SLOT = 2'd2;

	// request into the serial divider
	typedef struct packed {
		logic start;
		logic [DVD_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
		logic [CNT_W-1:0] nbits;
	} div_req_t;

	// response from the serial divider
	typedef struct packed {
		logic done;
		logic [QUO_W-1:0] quo;
		logic [DSR_W-1:0] rem;
	} div_rsp_t;

	// day of year at which month idx+1 starts
	function automatic logic [DOY_W-1:0] month_start(input logic leap,
			input logic [MONTH_W-1:0] idx);
		logic [DOY_W-1:0] base;
		unique case (idx)
			4'd0: base = 9'd0;
			4'd1: base = 9'd31;
			4'd2: base = 9'd59;
			4'd3: base = 9'd90;
			4'd4: base = 9'd120;
			4'd5: base = 9'd151;
			4'd6: base = 9'd181;
			4'd7: base = 9'd212;
			4'd8: base = 9'd243;
			4'd9: base = 9'd273;
			4'd10: base = 9'd304;
			4'd11: base = 9'd334;
			4'd12: base = 9'd365;
			default: base = 9'd0;
		endcase
		return base + ((leap && idx >= 4'd2) ? 9'd1 : 9'd0);
	endfunction

endpackage

@@ src/emscal_if.sv @@
// valid/ready channels carrying the input word and the result word
interface emscal_in_if import emscal_pkg::*; ();
	logic valid;
	logic ready;
	logic [EPOCH_W-1:0] epoch_millis;

	modport source (output valid, output epoch_millis, input ready);
	modport sink (input valid, input epoch_millis, output ready);
endinterface

interface emscal_out_if import emscal_pkg::*; ();
	logic valid;
	logic ready;
	logic [YEAR_W-1:0] year_out;
	logic [MONTH_W-1:0] month_out;
	logic [MDAY_W-1:0] day_of_month;
	logic [WDAY_W-1:0] weekday_out;
	logic [HOUR_W-1:0] hour_out;
	logic [MIN_W-1:0] minute_out;
	logic [SEC_W-1:0] second_out;
	logic [MILLI_W-1:0] milli_out;
	logic range_error;

	modport source (output valid, output year_out, output month_out, output day_of_month,
		output weekday_out, output hour_out, output minute_out, output second_out,
		output milli_out, output range_error, input ready);
	modport sink (input valid, input year_out, input month_out, input day_of_month,
		input weekday_out, input hour_out, input minute_out, input second_out,
		input milli_out, input range_error, output ready);
endinterface

@@ src/emscal_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
module emscal_div import emscal_pkg::*; (
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output div_rsp_t rsp
);

	logic [DSR_W-1:0] rem_q;
	logic [QUO_W-1:0] num_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic done_q;
	logic [DSR_W:0] trial;
	logic [DSR_W:0] diff;
	logic take;

	// trial subtract of the divisor from the shifted partial remainder
	assign trial = {rem_q, num_q[QUO_W-1]};
	assign diff = trial - {1'b0, req.divisor};
	assign take = trial >= {1'b0, req.divisor};

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= req.nbits;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	// remainder, dividend and quotient shift registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			// upper bits are below the divisor by construction of nbits
			rem_q <= DSR_W'(req.dividend >> req.nbits);
			num_q <= req.dividend[QUO_W-1:0] << (CNT_W'(QUO_W) - req.nbits);
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= take ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
			num_q <= {num_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], take};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;
	assign rsp.rem = rem_q;

	// a new division only starts once the previous one has finished
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> cnt_q == '0)
		else $error("divider started while busy");

	// remainder is fully reduced when the result is flagged
	a_rem_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> rem_q < req.divisor)
		else $error("divider remainder not below divisor");

	// done pulse only after the last step
	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> cnt_q == '0 && $past(cnt_q) == CNT_W'(1))
		else $error("divider done without finishing the count");

endmodule

@@ src/emscal_month.sv @@
// month and day of month from day of year and leap flag
module emscal_month import emscal_pkg::*; (
	input logic [DOY_W-1:0] doy,
	input logic leap,
	output logic [MONTH_W-1:0] month,
	output logic [MDAY_W-1:0] mday
);

	logic [10:0] past;
	logic [DOY_W-1:0] base;

	// months 2 to 12 whose start is already behind the day
	always_comb begin
		for (int i = 1; i < 12; i++) begin
			past[i-1] = doy >= month_start(leap, MONTH_W'(i));
		end
	end

	// thresholds rise, so the count of passed starts picks the month
	always_comb begin
		month = MONTH_W'(1) + MONTH_W'($countones(past));
		base = month_start(leap, month - MONTH_W'(1));
		mday = MDAY_W'(doy - base + DOY_W'(1));
	end

endmodule

@@ src/epoch_ms_to_calendar_time_unit.sv @@
// epoch milliseconds to calendar date and time of day, shifted by a whole-hour zone
// an accepted word is range checked; an out-of-range time goes straight to the result register,
// while an in-range time runs six serial divisions (day, milli, second, minute, weekday,
// four-year block) that share one bit-serial divider at one quotient bit per cycle
// a new word is taken only in idle, once the last one is through its passes; also while the result waits
// reset: asynchronous, active low; zone offset returns to +3 hours, channels empty
module epoch_ms_to_calendar_time_unit import emscal_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic signed [ZONE_W-1:0] zone_hours,
	emscal_in_if.sink in_ch,
	emscal_out_if.source out_ch
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DAY,
		ST_MILLI,
		ST_SEC,
		ST_MIN,
		ST_WEEK,
		ST_QUAD,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic signed [ZMS_W-1:0] zone_ms_q;
	logic signed [TIME_W-1:0] t_q;
	logic [DAYS_W-1:0] days_q;
	logic [QUAD_W-1:0] quad_q;
	logic [1:0] yoff_q;
	logic [DOY_W-1:0] doy_q;
	logic leap_q;
	logic err_q;
	logic div_start_q;
	logic [DVD_W-1:0] div_dvd_q;
	logic [DSR_W-1:0] div_dsr_q;
	logic [CNT_W-1:0] div_n_q;
	logic [WDAY_W-1:0] wday_wk_q;
	logic [HOUR_W-1:0] hour_wk_q;
	logic [MIN_W-1:0] minute_wk_q;
	logic [SEC_W-1:0] second_wk_q;
	logic [MILLI_W-1:0] milli_wk_q;
	logic out_valid_q;
	logic [YEAR_W-1:0] year_q;
	logic [MONTH_W-1:0] month_q;
	logic [MDAY_W-1:0] mday_q;
	logic [WDAY_W-1:0] wday_q;
	logic [HOUR_W-1:0] hour_q;
	logic [MIN_W-1:0] minute_q;
	logic [SEC_W-1:0] second_q;
	logic [MILLI_W-1:0] milli_q;
	logic range_q;
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic [MONTH_W-1:0] mon_w;
	logic [MDAY_W-1:0] mday_w;
	logic [10:0] qrem;

	// zone offset kept as milliseconds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_ms_q <= ZONE_MS_RST;
		end else if (cfg_wr_en) begin
			zone_ms_q <= ZMS_W'(ZMS_W'(zone_hours) * MS_PER_HOUR);
		end
	end

	assign div_req.start = div_start_q;
	assign div_req.dividend = div_dvd_q;
	assign div_req.divisor = div_dsr_q;
	assign div_req.nbits = div_n_q;

	emscal_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	emscal_month u_month (
		.doy(doy_q),
		.leap(leap_q),
		.month(mon_w),
		.mday(mday_w)
	);

	assign qrem = div_rsp.rem[10:0];
	assign in_ch.ready = (state_q == ST_IDLE);

	// sequencer over the division passes, with the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (out_valid_q && out_ch.ready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						t_q <= $signed({1'b0, in_ch.epoch_millis}) + TIME_W'(zone_ms_q);
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (t_q[TIME_W-1] || t_q[EPOCH_W-1:0] >= SPAN_MS) begin
						err_q <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						err_q <= 1'b0;
						div_dvd_q <= t_q[EPOCH_W-1:0];
						div_dsr_q <= DIV_DAY;
						div_n_q <= NB_DAY;
						div_start_q <= 1'b1;
						state_q <= ST_DAY;
					end
				end
				ST_DAY: begin
					if (div_rsp.done) begin
						days_q <= div_rsp.quo[DAYS_W-1:0];
						div_dvd_q <= DVD_W'(div_rsp.rem);
						div_dsr_q <= DIV_MILLI;
						div_n_q <= NB_MILLI;
						div_start_q <= 1'b1;
						state_q <= ST_MILLI;
					end
				end
				ST_MILLI: begin
					if (div_rsp.done) begin
						milli_wk_q <= div_rsp.rem[MILLI_W-1:0];
						div_dvd_q <= DVD_W'(div_rsp.quo);
						div_dsr_q <= DIV_SIXTY;
						div_n_q <= NB_SEC;
						div_start_q <= 1'b1;
						state_q <= ST_SEC;
					end
				end
				ST_SEC: begin
					if (div_rsp.done) begin
						second_wk_q <= div_rsp.rem[SEC_W-1:0];
						div_dvd_q <= DVD_W'(div_rsp.quo);
						div_dsr_q <= DIV_SIXTY;
						div_n_q <= NB_MIN;
						div_start_q <= 1'b1;
						state_q <= ST_MIN;
					end
				end
				ST_MIN: begin
					if (div_rsp.done) begin
						minute_wk_q <= div_rsp.rem[MIN_W-1:0];
						hour_wk_q <= div_rsp.quo[HOUR_W-1:0];
						// 1970-01-01 was a thursday
						div_dvd_q <= DVD_W'(days_q) + DVD_W'(3);
						div_dsr_q <= DIV_WEEK;
						div_n_q <= NB_WEEK;
						div_start_q <= 1'b1;
						state_q <= ST_WEEK;
					end
				end
				ST_WEEK: begin
					if (div_rsp.done) begin
						wday_wk_q <= div_rsp.rem[WDAY_W-1:0];
						div_dvd_q <= DVD_W'(days_q);
						div_dsr_q <= DIV_QUAD;
						div_n_q <= NB_QUAD;
						div_start_q <= 1'b1;
						state_q <= ST_QUAD;
					end
				end
				ST_QUAD: begin
					if (div_rsp.done) begin
						quad_q <= div_rsp.quo[QUAD_W-1:0];
						// year inside the block: 365, 365, 366, 365 days
						priority if (qrem < QY1) begin
							yoff_q <= 2'd0;
							doy_q <= DOY_W'(qrem);
						end else if (qrem < QY2) begin
							yoff_q <= 2'd1;
							doy_q <= DOY_W'(qrem - QY1);
						end else if (qrem < QY3) begin
							yoff_q <= LEAP_SLOT;
							doy_q <= DOY_W'(qrem - QY2);
						end else begin
							yoff_q <= 2'd3;
							doy_q <= DOY_W'(qrem - QY3);
						end
						leap_q <= (qrem >= QY2) && (qrem < QY3);
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						if (err_q) begin
							year_q <= '0;
							month_q <= '0;
							mday_q <= '0;
							wday_q <= '0;
							hour_q <= '0;
							minute_q <= '0;
							second_q <= '0;
							milli_q <= '0;
							range_q <= 1'b1;
						end else begin
							year_q <= FIRST_YEAR + YEAR_W'({quad_q, 2'b00}) + YEAR_W'(yoff_q);
							month_q <= mon_w;
							mday_q <= mday_w;
							wday_q <= wday_wk_q;
							hour_q <= hour_wk_q;
							minute_q <= minute_wk_q;
							second_q <= second_wk_q;
							milli_q <= milli_wk_q;
							range_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.year_out = year_q;
	assign out_ch.month_out = month_q;
	assign out_ch.day_of_month = mday_q;
	assign out_ch.weekday_out = wday_q;
	assign out_ch.hour_out = hour_q;
	assign out_ch.minute_out = minute_q;
	assign out_ch.second_out = second_q;
	assign out_ch.milli_out = milli_q;
	assign out_ch.range_error = range_q;

	// out-of-span word carries no date or time
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && range_q |-> year_q == '0 && month_q == '0 && mday_q == '0
			&& hour_q == '0 && milli_q == '0)
		else $error("range error word with nonzero fields");

	// in-span word holds a proper date
	a_date_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !range_q |-> month_q >= MONTH_W'(1) && month_q <= MONTH_W'(12)
			&& mday_q >= MDAY_W'(1) && year_q >= FIRST_YEAR && year_q <= YEAR_W'(2099))
		else $error("calendar fields out of range");

	// divider only kicked off from the range check or a finished pass
	a_start_src: assert property (@(posedge clk) disable iff (!arst_n)
		div_start_q |-> $past(state_q) == ST_CHECK || $past(div_rsp.done))
		else $error("divider start without a finished pass");

endmodule
